[sv/bco_pkg.sv]
// bco_pkg: shared constants, field widths and types of the binary cross
// morphology block. No dependencies.
`timescale 1ns / 1ps

package bco_pkg;

  // Default line length limit (pixels per line)
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  // Default depth of the front/back queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Register and field widths
  localparam int unsigned IMG_W_W    = 11;
  localparam int unsigned IMG_H_W    = 13;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned OUT_DATA_W = 8;
  // Row positions run up to three lines past the frame while draining
  localparam int unsigned ROW_W      = IMG_H_W + 1;

  // Register reset values
  localparam logic [IMG_W_W-1:0] WIDTH_RST  = IMG_W_W'(512);
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = IMG_H_W'(512);
  localparam logic [THR_W-1:0]   THR_RST    = THR_W'(130);
  localparam logic [MODE_W-1:0]  MODE_RST   = MODE_W'(2);

  typedef enum logic [MODE_W-1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_e;

  // Raw mode register to frame mode; the unused code runs as opening.
  function automatic mode_e to_mode(input logic [MODE_W-1:0] raw);
    mode_e m;
    case (raw)
      MODE_ERODE:  m = MODE_ERODE;
      MODE_DILATE: m = MODE_DILATE;
      default:     m = MODE_OPEN;
    endcase
    return m;
  endfunction

endpackage

[sv/bco_ram.sv]
// bco_ram: generic single-write, single-read RAM with registered read data.
// Write-first on a same-address collision. No dependencies.
`timescale 1ns / 1ps

module bco_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bco_fifo.sv]
// bco_fifo: short register queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

module bco_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[sv/bco_front.sv]
// bco_front: config registers, request intake, binarization and raster
// position tracking. Depends on bco_pkg.
`timescale 1ns / 1ps

module bco_front #(
  parameter int unsigned MAX_WIDTH = bco_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COL_W     = $clog2(MAX_WIDTH),
  parameter int unsigned FW_W      = $clog2(MAX_WIDTH + 1),
  parameter int unsigned ENTRY_W   = 1 + COL_W + bco_pkg::ROW_W + FW_W
                                     + bco_pkg::IMG_H_W + bco_pkg::MODE_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [bco_pkg::PIX_W-1:0]      s_tdata_i,
  input  logic                           s_tuser_i,
  input  logic                           cfg_we_i,
  input  logic [bco_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bco_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output logic [ENTRY_W-1:0]             q_data_o
);

  localparam logic KIND_PIXEL = 1'b0;

  typedef enum logic [bco_pkg::CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                         px;
    logic [COL_W-1:0]             col;
    logic [bco_pkg::ROW_W-1:0]    row;
    logic [FW_W-1:0]              fw;
    logic [bco_pkg::IMG_H_W-1:0]  fh;
    bco_pkg::mode_e               mode;
  } entry_t;

  logic [bco_pkg::IMG_W_W-1:0] width_q;
  logic [bco_pkg::IMG_H_W-1:0] height_q;
  logic [bco_pkg::THR_W-1:0]   thr_q;
  logic [bco_pkg::MODE_W-1:0]  mode_q;

  logic                        active_q, active_d;
  logic [COL_W-1:0]            col_q, col_d, col_c;
  logic [bco_pkg::ROW_W-1:0]   row_q, row_d, row_c;
  logic [FW_W-1:0]             fw_q, fw_new, fw_c;
  logic [bco_pkg::IMG_H_W-1:0] fh_q, fh_new, fh_c;
  bco_pkg::mode_e              fmode_q, fmode_c;

  logic   accept, is_pixel, draining, counted, last_item, col_wrap;
  entry_t entry;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bco_pkg::WIDTH_RST;
      height_q <= bco_pkg::HEIGHT_RST;
      thr_q    <= bco_pkg::THR_RST;
      mode_q   <= bco_pkg::MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_wdata_i[bco_pkg::IMG_W_W-1:0];
        REG_HEIGHT: height_q <= cfg_wdata_i[bco_pkg::IMG_H_W-1:0];
        REG_THRESH: thr_q    <= cfg_wdata_i[bco_pkg::THR_W-1:0];
        REG_MODE:   mode_q   <= cfg_wdata_i[bco_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame geometry as it would be latched now
  always_comb begin
    if (32'(width_q) > MAX_WIDTH) begin
      fw_new = FW_W'(MAX_WIDTH);
    end else if (width_q == '0) begin
      fw_new = FW_W'(1);
    end else begin
      fw_new = FW_W'(width_q);
    end
    fh_new = (height_q == '0) ? bco_pkg::IMG_H_W'(1) : height_q;
  end

  assign fw_c    = active_q ? fw_q : fw_new;
  assign fh_c    = active_q ? fh_q : fh_new;
  assign fmode_c = active_q ? fmode_q : bco_pkg::to_mode(mode_q);
  assign col_c   = active_q ? col_q : '0;
  assign row_c   = active_q ? row_q : '0;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign is_pixel   = (s_tuser_i == KIND_PIXEL);
  // all pixels of the frame are in: every item now counts as a drain tick
  assign draining   = active_q && (row_q >= bco_pkg::ROW_W'(fh_q));
  assign counted    = accept && (is_pixel || draining);
  assign col_wrap   = (FW_W'(col_c) == fw_c - FW_W'(1));

  // Position of the frame's final item (the last result is made from it)
  always_comb begin
    if (fmode_c == bco_pkg::MODE_OPEN) begin
      if (fw_c == FW_W'(1)) begin
        last_item = (row_c == bco_pkg::ROW_W'(fh_c) + bco_pkg::ROW_W'(3)) && (col_c == '0);
      end else begin
        last_item = (row_c == bco_pkg::ROW_W'(fh_c) + bco_pkg::ROW_W'(2))
                    && (col_c == COL_W'(1));
      end
    end else begin
      last_item = (row_c == bco_pkg::ROW_W'(fh_c) + bco_pkg::ROW_W'(1)) && (col_c == '0);
    end
  end

  always_comb begin
    active_d = active_q;
    col_d    = col_q;
    row_d    = row_q;
    if (counted) begin
      if (last_item) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        col_d    = col_wrap ? '0 : col_c + COL_W'(1);
        row_d    = col_wrap ? row_c + bco_pkg::ROW_W'(1) : row_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      fw_q     <= FW_W'(bco_pkg::WIDTH_RST);
      fh_q     <= bco_pkg::HEIGHT_RST;
      fmode_q  <= bco_pkg::MODE_OPEN;
    end else begin
      active_q <= active_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (counted && !active_q) begin
        fw_q    <= fw_new;
        fh_q    <= fh_new;
        fmode_q <= bco_pkg::to_mode(mode_q);
      end
    end
  end

  always_comb begin
    entry.px   = !draining && is_pixel && (s_tdata_i > thr_q);
    entry.col  = col_c;
    entry.row  = row_c;
    entry.fw   = fw_c;
    entry.fh   = fh_c;
    entry.mode = fmode_c;
  end

  assign q_push_o = counted;
  assign q_data_o = entry;

endmodule

[sv/bco_window.sv]
// bco_window: one 3x3 cross window stage over a raster bit stream, with a
// two-line buffer RAM. Depends on bco_pkg and bco_ram.
`timescale 1ns / 1ps

module bco_window #(
  parameter int unsigned MAX_WIDTH = bco_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COL_W     = $clog2(MAX_WIDTH),
  parameter int unsigned FW_W      = $clog2(MAX_WIDTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic                          x_i,
  input  logic [COL_W-1:0]              col_i,
  input  logic [bco_pkg::ROW_W-1:0]     row_i,
  input  logic [FW_W-1:0]               fw_i,
  input  logic [bco_pkg::IMG_H_W-1:0]   fh_i,
  output logic                          started_o,
  output logic [COL_W-1:0]              ccol_o,
  output logic [bco_pkg::ROW_W-1:0]     crow_o,
  output logic                          ero_o,
  output logic                          dil_o
);

  // word per column: [1] bit one line back, [0] bit two lines back
  logic [1:0]       rd;
  logic [COL_W-1:0] raddr;
  logic             down_q, ctr_q, left_q, up_q;
  logic             l_ok, r_ok, u_ok, d_ok;
  logic             nb_l, nb_r, nb_u, nb_d;

  // read ahead the column of the next item
  assign raddr = (FW_W'(col_i) == fw_i - FW_W'(1)) ? '0 : col_i + COL_W'(1);

  bco_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (adv_i),
    .waddr_i (col_i),
    .wdata_i ({x_i, rd[1]}),
    .re_i    (adv_i),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      down_q <= x_i;
      ctr_q  <= rd[1];
      left_q <= ctr_q;
      up_q   <= rd[0];
    end
  end

  // center sits one line and one pixel behind the incoming bit
  always_comb begin
    if (col_i != '0) begin
      ccol_o    = col_i - COL_W'(1);
      crow_o    = row_i - bco_pkg::ROW_W'(1);
      started_o = (row_i >= bco_pkg::ROW_W'(1));
    end else begin
      ccol_o    = COL_W'(fw_i - FW_W'(1));
      crow_o    = row_i - bco_pkg::ROW_W'(2);
      started_o = (row_i >= bco_pkg::ROW_W'(2));
    end
  end

  // zero padding at the frame border
  assign l_ok = (ccol_o != '0);
  assign r_ok = (FW_W'(ccol_o) != fw_i - FW_W'(1));
  assign u_ok = (crow_o != '0);
  assign d_ok = (crow_o != bco_pkg::ROW_W'(fh_i) - bco_pkg::ROW_W'(1));

  assign nb_l = l_ok && left_q;
  assign nb_r = r_ok && rd[1];
  assign nb_u = u_ok && up_q;
  assign nb_d = d_ok && down_q;

  assign ero_o = ctr_q && nb_l && nb_r && nb_u && nb_d;
  assign dil_o = ctr_q || nb_l || nb_r || nb_u || nb_d;

endmodule

[sv/bco_back.sv]
// bco_back: window stages (erosion, then dilation for opening) and the
// result register. Depends on bco_pkg and bco_window.
`timescale 1ns / 1ps

module bco_back #(
  parameter int unsigned MAX_WIDTH = bco_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COL_W     = $clog2(MAX_WIDTH),
  parameter int unsigned FW_W      = $clog2(MAX_WIDTH + 1),
  parameter int unsigned ENTRY_W   = 1 + COL_W + bco_pkg::ROW_W + FW_W
                                     + bco_pkg::IMG_H_W + bco_pkg::MODE_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  logic [ENTRY_W-1:0]              q_data_i,
  output logic                            q_pop_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [bco_pkg::OUT_DATA_W-1:0]  m_tdata_o,
  output logic                            m_tlast_o
);

  typedef struct packed {
    logic                         px;
    logic [COL_W-1:0]             col;
    logic [bco_pkg::ROW_W-1:0]    row;
    logic [FW_W-1:0]              fw;
    logic [bco_pkg::IMG_H_W-1:0]  fh;
    bco_pkg::mode_e               mode;
  } entry_t;

  entry_t                    e;
  logic                      pop;
  logic                      s1_started, s1_ero, s1_dil, s1_in;
  logic [COL_W-1:0]          s1_ccol;
  logic [bco_pkg::ROW_W-1:0] s1_crow;
  logic                      s2_adv, s2_started, s2_ero, s2_dil, s2_in;
  logic [COL_W-1:0]          s2_ccol;
  logic [bco_pkg::ROW_W-1:0] s2_crow;
  logic                      s1_last, s2_last;
  logic                      res_vld, res_fg, res_last;
  logic                      out_vld_q, fg_q, last_q;

  assign e   = q_data_i;
  assign pop = q_valid_i && (!out_vld_q || m_tready_i);

  bco_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .FW_W      (FW_W)
  ) u_win1 (
    .clk_i     (clk_i),
    .adv_i     (pop),
    .x_i       (e.px),
    .col_i     (e.col),
    .row_i     (e.row),
    .fw_i      (e.fw),
    .fh_i      (e.fh),
    .started_o (s1_started),
    .ccol_o    (s1_ccol),
    .crow_o    (s1_crow),
    .ero_o     (s1_ero),
    .dil_o     (s1_dil)
  );

  assign s1_in   = s1_started && (s1_crow < bco_pkg::ROW_W'(e.fh));
  assign s1_last = (s1_crow == bco_pkg::ROW_W'(e.fh) - bco_pkg::ROW_W'(1))
                   && (FW_W'(s1_ccol) == e.fw - FW_W'(1));

  // second stage runs on the eroded stream, positioned at stage one's center
  assign s2_adv = pop && (e.mode == bco_pkg::MODE_OPEN) && s1_started;

  bco_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .FW_W      (FW_W)
  ) u_win2 (
    .clk_i     (clk_i),
    .adv_i     (s2_adv),
    .x_i       (s1_in && s1_ero),
    .col_i     (s1_ccol),
    .row_i     (s1_crow),
    .fw_i      (e.fw),
    .fh_i      (e.fh),
    .started_o (s2_started),
    .ccol_o    (s2_ccol),
    .crow_o    (s2_crow),
    .ero_o     (s2_ero),
    .dil_o     (s2_dil)
  );

  assign s2_in   = s1_started && s2_started && (s2_crow < bco_pkg::ROW_W'(e.fh))
                   && !(s2_ero && !s2_dil);
  assign s2_last = (s2_crow == bco_pkg::ROW_W'(e.fh) - bco_pkg::ROW_W'(1))
                   && (FW_W'(s2_ccol) == e.fw - FW_W'(1));

  always_comb begin
    case (e.mode)
      bco_pkg::MODE_ERODE: begin
        res_vld  = s1_in;
        res_fg   = s1_ero;
        res_last = s1_last;
      end
      bco_pkg::MODE_DILATE: begin
        res_vld  = s1_in;
        res_fg   = s1_dil;
        res_last = s1_last;
      end
      bco_pkg::MODE_OPEN: begin
        res_vld  = s2_in;
        res_fg   = s2_dil;
        res_last = s2_last;
      end
      default: begin
        res_vld  = 1'b0;
        res_fg   = 1'b0;
        res_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop) begin
      out_vld_q <= res_vld;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_vld) begin
      fg_q   <= res_fg;
      last_q <= res_last;
    end
  end

  assign q_pop_o    = pop;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {(bco_pkg::OUT_DATA_W - 1)'(0), fg_q};
  assign m_tlast_o  = out_vld_q && last_q;

endmodule

[sv/binary_cross_morphology_open_top.sv]
// A result leaves via queue and result register after the item completing
// its window: i+W+1 (erosion, dilation) or i+2W+2 (opening). One item per
// cycle unless the result port stalls, set by the read-ahead line RAM port
// of each window stage. Reset (async, active low) clears positions, queue
// and result register; line RAMs keep stale bits, masked by frame position.
`timescale 1ns / 1ps

// Top level: front (config, intake, binarize, raster position), two-entry
// queue, back (cross windows, result register). Depends on bco_pkg,
// bco_front, bco_fifo, bco_back.
module binary_cross_morphology_open_top #(
  parameter int unsigned MAX_WIDTH   = bco_pkg::MAX_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = bco_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input requests
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [bco_pkg::PIX_W-1:0]      s_axis_tdata_i,   // [7:0] gray_pixel
  input  logic [0:0]                     s_axis_tuser_i,   // [0] kind (1 = flush)
  // results
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [bco_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // [0] fg, [7:1] zero
  output logic                           m_axis_tlast_o,   // frame_last
  // config writes: 0 width, 1 height, 2 threshold, 3 mode
  input  logic                           cfg_we_i,
  input  logic [bco_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bco_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned FW_W    = $clog2(MAX_WIDTH + 1);
  // queue entry: bit, column, row, frame width, height and mode
  localparam int unsigned ENTRY_W = 1 + COL_W + bco_pkg::ROW_W + FW_W
                                    + bco_pkg::IMG_H_W + bco_pkg::MODE_W;

  logic               q_push, q_pop, q_valid, q_full;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // Front: takes a request whenever the queue has room; early flushes are
  // dropped here, pixels are thresholded and tagged with their raster
  // position. Frame geometry and mode latch on the first pixel of a frame.
  bco_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .FW_W      (FW_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i[0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Queue decouples intake from a stalled result port
  bco_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata),
    .full_o  (q_full)
  );

  // Back: window stages and the output register; pops one entry per cycle
  // whenever one is waiting and the output register is free or being drained.
  bco_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .FW_W      (FW_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

[sv/bco_sva_chk.sv]
// bco_sva_chk: port-level checks of the morphology top level, bound to it.
// Depends on bco_pkg and binary_cross_morphology_open_top.
`timescale 1ns / 1ps

module bco_sva_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bco_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("result payload changed while stalled");

  // intake only backs up behind a stalled result port
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("intake blocked without output backpressure");

  // only the pixel bit of the result word is ever set, and frame end is
  // only flagged on a valid result
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o || m_axis_tlast_o) |->
      (m_axis_tvalid_o && (m_axis_tdata_o[bco_pkg::OUT_DATA_W-1:1] == '0)))
    else $error("bad result word");

endmodule

bind binary_cross_morphology_open_top bco_sva_chk u_sva_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[sim/binary_cross_morphology_open_top_tb.sv]
// Self-checking bench for binary_cross_morphology_open_top: every result is
// scored against a cross-window erosion/dilation/opening predictor or a
// hand-typed result. Depends on bco_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module binary_cross_morphology_open_top_tb;

  localparam int unsigned MAX_W          = bco_pkg::MAX_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 8;     // settle margin after the last owed result
  localparam int unsigned HOLD_CYCLES    = 400;   // long sink stall to back up the block
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam bit KIND_PIXEL = 1'b0;
  localparam bit KIND_FLUSH = 1'b1;
  // unused mode code, runs as opening
  localparam logic [bco_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef enum bit [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_MODE      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    bit fg;
    bit last;
  } pixel_res_t;

  localparam pixel_res_t NO_RES = '0;

  // Directed table: register write, predictor-checked item, or item with a
  // hand-typed result.
  typedef enum bit [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECK} row_op_e;

  typedef struct packed {
    row_op_e          op;
    cfg_reg_e         sel;
    logic [12:0]      value;
    bit               kind;
    logic [7:0]       gray;
    pixel_res_t       res;
  } dir_row_t;

  // ---------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------
  logic                           clk_i;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [bco_pkg::PIX_W-1:0]      s_axis_tdata_i  = '0;   // [7:0] gray_pixel
  logic [0:0]                     s_axis_tuser_i  = '0;   // [0] kind
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [bco_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;         // [0] fg, [7:1] zero
  logic                           m_axis_tlast_o;         // frame_last
  logic                           cfg_we_i        = 1'b0;
  logic [bco_pkg::CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [bco_pkg::CFG_DATA_W-1:0] cfg_wdata_i     = '0;

  binary_cross_morphology_open_top dut (.*);

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor state: register copies, per-frame latch, line rings
  // ---------------------------------------------------------------------
  logic [bco_pkg::IMG_W_W-1:0] reg_width  = bco_pkg::WIDTH_RST;
  logic [bco_pkg::IMG_H_W-1:0] reg_height = bco_pkg::HEIGHT_RST;
  logic [bco_pkg::THR_W-1:0]   reg_thr    = bco_pkg::THR_RST;
  logic [bco_pkg::MODE_W-1:0]  reg_mode   = bco_pkg::MODE_RST;

  int unsigned    frame_pos = 0;      // items taken in the current frame
  int unsigned    frm_w     = 512;
  int unsigned    frm_h     = 512;
  bco_pkg::mode_e frm_mode  = bco_pkg::MODE_OPEN;

  // Four-row rings of binarized and eroded bits
  bit bin_ring [4][MAX_W];
  bit ero_ring [4][MAX_W];

  pixel_res_t  pending_pixels [$];  // results still owed by the block
  dir_row_t    dir_rows [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned live_items   = 0;    // random items that advanced a frame
  bit          sender_calm  = 1'b0;
  bit          hold_req     = 1'b0;

  // Bit of a ring with zero padding outside the latched frame
  function automatic int unsigned ring_bit(bit eroded, int r, int c);
    if (r < 0 || c < 0 || r >= int'(frm_h) || c >= int'(frm_w)) return 0;
    return eroded ? ero_ring[r % 4][c] : bin_ring[r % 4][c];
  endfunction

  // Ones under the plus-shaped window centered on raster index idx
  function automatic int unsigned cross_ones(bit eroded, int unsigned idx);
    int r;
    int c;
    r = int'(idx / frm_w);
    c = int'(idx % frm_w);
    return ring_bit(eroded, r, c) + ring_bit(eroded, r - 1, c) +
           ring_bit(eroded, r + 1, c) + ring_bit(eroded, r, c - 1) +
           ring_bit(eroded, r, c + 1);
  endfunction

  // Advance the frame by one accepted request; returns 1 if it owes a result.
  function automatic bit cross_morph_step(bit kind, logic [7:0] gray,
                                          output pixel_res_t res);
    int unsigned n;
    int unsigned d;
    int unsigned k;
    int unsigned e;
    int unsigned i;
    bit          made;
    res  = NO_RES;
    made = 1'b0;
    if (frame_pos == 0) begin
      // flush with no frame open is dropped; a pixel latches the geometry
      if (kind == KIND_FLUSH) return 1'b0;
      frm_w    = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
      frm_h    = (reg_height == 0) ? 1 : reg_height;
      frm_mode = (reg_mode == MODE_SPARE) ? bco_pkg::MODE_OPEN : bco_pkg::mode_e'(reg_mode);
    end
    n = frm_w * frm_h;
    d = (frm_mode == bco_pkg::MODE_OPEN) ? 2 * frm_w + 2 : frm_w + 1;
    k = frame_pos;
    if (k < n) begin
      if (kind == KIND_FLUSH) return 1'b0;  // early flush
      bin_ring[(k / frm_w) % 4][k % frm_w] = (gray > reg_thr);
    end
    // opening: first stage erodes one line plus one pixel behind intake
    if (frm_mode == bco_pkg::MODE_OPEN && k >= frm_w + 1 && k - (frm_w + 1) < n) begin
      e = k - (frm_w + 1);
      ero_ring[(e / frm_w) % 4][e % frm_w] = (cross_ones(1'b0, e) == 5);
    end
    if (k >= d && k - d < n) begin
      i = k - d;
      case (frm_mode)
        bco_pkg::MODE_ERODE:  res.fg = (cross_ones(1'b0, i) == 5);
        bco_pkg::MODE_DILATE: res.fg = (cross_ones(1'b0, i) != 0);
        default:              res.fg = (cross_ones(1'b1, i) != 0);
      endcase
      res.last = (i == n - 1);
      made     = 1'b1;
    end
    frame_pos = (k + 1 >= n + d) ? 0 : k + 1;
    return made;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------
  function automatic dir_row_t cfg_row(cfg_reg_e sel, int unsigned v);
    dir_row_t r;
    r       = '0;
    r.op    = ROW_CFG;
    r.sel   = sel;
    r.value = 13'(v);
    return r;
  endfunction

  function automatic dir_row_t item_row(bit kind, int unsigned gray);
    dir_row_t r;
    r      = '0;
    r.op   = ROW_ITEM;
    r.kind = kind;
    r.gray = 8'(gray);
    return r;
  endfunction

  function automatic dir_row_t check_row(bit kind, int unsigned gray, bit fg, bit last);
    dir_row_t r;
    r          = item_row(kind, gray);
    r.op       = ROW_CHECK;
    r.res.fg   = fg;
    r.res.last = last;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (sender_calm) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(50, 12);
  endfunction

  // Gray value on the foreground side of the threshold with chance dense %
  function automatic logic [7:0] pick_gray(int unsigned dense);
    if ($urandom_range(99) < dense && reg_thr != 8'hFF)
      return 8'($urandom_range(255, int'(reg_thr) + 1));
    return 8'($urandom_range(int'(reg_thr), 0));
  endfunction

  // Offer one request, wait for the handshake, then record what it owes.
  task automatic send_item(bit kind, logic [7:0] gray, bit typed, pixel_res_t typed_res);
    int unsigned gap;
    pixel_res_t  res;
    bit          made;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= gray;
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    made = cross_morph_step(kind, gray, res);
    if (typed) begin
      res  = typed_res;
      made = 1'b1;
    end
    if (made) pending_pixels.push_back(res);
  endtask

  // Drop valid and wait until every owed result is out and the pipe is quiet.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e sel, int unsigned v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= bco_pkg::CFG_DATA_W'(v);
    case (sel)
      REG_WIDTH:     reg_width  = bco_pkg::IMG_W_W'(v);
      REG_HEIGHT:    reg_height = bco_pkg::IMG_H_W'(v);
      REG_THRESHOLD: reg_thr    = bco_pkg::THR_W'(v);
      default:       reg_mode   = bco_pkg::MODE_W'(v);
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One whole frame: pixels with stray early flushes, then drain ticks,
  // some of them pixels that the block must treat as drain.
  task automatic run_frame(int unsigned dense);
    int unsigned total;
    int unsigned px_sent;
    send_item(KIND_PIXEL, pick_gray(dense), 1'b0, NO_RES);
    live_items++;
    total   = frm_w * frm_h;
    px_sent = 1;
    while (frame_pos != 0) begin
      if (px_sent < total) begin
        if ($urandom_range(19) == 0)
          send_item(KIND_FLUSH, 8'($urandom_range(255)), 1'b0, NO_RES);
        send_item(KIND_PIXEL, pick_gray(dense), 1'b0, NO_RES);
        px_sent++;
      end else if ($urandom_range(6) == 0) begin
        send_item(KIND_PIXEL, 8'($urandom_range(255)), 1'b0, NO_RES);
      end else begin
        send_item(KIND_FLUSH, 8'($urandom_range(255)), 1'b0, NO_RES);
      end
      live_items++;
    end
  endtask

  function automatic int unsigned pick_dense();
    return ($urandom_range(2) == 0) ? $urandom_range(100, 85) : $urandom_range(100);
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned roll;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register reset values: the frame is cut down to three short lines;
    // threshold 130 and opening stay as reset.
    wait_idle();
    write_reg(REG_WIDTH, 6);
    write_reg(REG_HEIGHT, 3);
    run_frame(90);

    // Directed table
    // 1x1 dilation, threshold at its floor: stray flush, then 255 and 0
    dir_rows.push_back(cfg_row(REG_WIDTH, 1));
    dir_rows.push_back(cfg_row(REG_HEIGHT, 1));
    dir_rows.push_back(cfg_row(REG_THRESHOLD, 0));
    dir_rows.push_back(cfg_row(REG_MODE, bco_pkg::MODE_DILATE));
    dir_rows.push_back(item_row(KIND_FLUSH, 8'hA5));   // no frame open, dropped
    dir_rows.push_back(item_row(KIND_PIXEL, 255));
    dir_rows.push_back(item_row(KIND_FLUSH, 0));
    dir_rows.push_back(check_row(KIND_FLUSH, 0, 1'b1, 1'b1));
    dir_rows.push_back(item_row(KIND_PIXEL, 0));       // 0 is not above 0
    dir_rows.push_back(item_row(KIND_FLUSH, 8'h5A));
    dir_rows.push_back(check_row(KIND_FLUSH, 0, 1'b0, 1'b1));
    // 1x1 erosion: padding clears every pixel
    dir_rows.push_back(cfg_row(REG_MODE, bco_pkg::MODE_ERODE));
    dir_rows.push_back(item_row(KIND_PIXEL, 255));
    dir_rows.push_back(item_row(KIND_FLUSH, 0));
    dir_rows.push_back(check_row(KIND_FLUSH, 0, 1'b0, 1'b1));
    // 2x1 dilation: early flush dropped, pixel during drain counts as drain
    dir_rows.push_back(cfg_row(REG_WIDTH, 2));
    dir_rows.push_back(cfg_row(REG_MODE, bco_pkg::MODE_DILATE));
    dir_rows.push_back(item_row(KIND_PIXEL, 200));
    dir_rows.push_back(item_row(KIND_FLUSH, 0));
    dir_rows.push_back(item_row(KIND_PIXEL, 0));
    dir_rows.push_back(item_row(KIND_PIXEL, 77));
    dir_rows.push_back(check_row(KIND_FLUSH, 0, 1'b1, 1'b0));
    dir_rows.push_back(check_row(KIND_FLUSH, 0, 1'b1, 1'b1));
    // zero width and height act as one, spare mode opens, threshold at top
    dir_rows.push_back(cfg_row(REG_WIDTH, 0));
    dir_rows.push_back(cfg_row(REG_HEIGHT, 0));
    dir_rows.push_back(cfg_row(REG_THRESHOLD, 255));
    dir_rows.push_back(cfg_row(REG_MODE, MODE_SPARE));
    dir_rows.push_back(item_row(KIND_PIXEL, 255));
    dir_rows.push_back(item_row(KIND_FLUSH, 0));
    dir_rows.push_back(item_row(KIND_FLUSH, 0));
    dir_rows.push_back(item_row(KIND_FLUSH, 0));
    dir_rows.push_back(check_row(KIND_FLUSH, 0, 1'b0, 1'b1));

    foreach (dir_rows[j]) begin
      if (dir_rows[j].op == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[j].sel, dir_rows[j].value);
      end else begin
        send_item(dir_rows[j].kind, dir_rows[j].gray,
                  dir_rows[j].op == ROW_CHECK, dir_rows[j].res);
      end
    end

    // Tall single column; the sink is told to hold off so the block
    // fills and stalls intake.
    wait_idle();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 150);
    write_reg(REG_THRESHOLD, $urandom_range(200, 50));
    write_reg(REG_MODE, bco_pkg::MODE_DILATE);
    sender_calm = 1'b1;
    hold_req    = 1'b1;
    run_frame(50);
    sender_calm = 1'b0;

    // Random frames, mostly small
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      wait_idle();
      roll = $urandom_range(19);
      write_reg(REG_WIDTH, (roll == 0) ? 0 :
                (roll < 12) ? $urandom_range(5, 1) : $urandom_range(24, 6));
      roll = $urandom_range(19);
      write_reg(REG_HEIGHT, (roll == 0) ? 0 :
                (roll < 13) ? $urandom_range(5, 1) : $urandom_range(12, 6));
      roll = $urandom_range(19);
      write_reg(REG_THRESHOLD, (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(255));
      write_reg(REG_MODE, $urandom_range(3));
      sender_calm = ($urandom_range(4) == 0);
      // stray flushes between frames are dropped
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(2, 1))
          send_item(KIND_FLUSH, 8'($urandom_range(255)), 1'b0, NO_RES);
      end
      run_frame(pick_dense());
    end

    wait_idle();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result sink: random stalls in stretches, calm stretches, long hold-off
  // on request
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned stretch_left;
    int unsigned roll;
    bit          calm;
    stall_left   = 0;
    stretch_left = 0;
    calm         = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stretch_left == 0) begin
        calm         = ($urandom_range(3) == 0);
        stretch_left = $urandom_range(200, 20);
      end
      stretch_left--;
      if (stall_left == 0 && !calm) begin
        roll = $urandom_range(99);
        if (roll < 25) stall_left = $urandom_range(3, 1);
        else if (roll < 28) stall_left = $urandom_range(60, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  initial begin : result_check
    pixel_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (pending_pixels.size() == 0) begin
          flag_mismatch($sformatf("result %0d unexpected: data 0x%02h last %b",
                                  results_seen, m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          want = pending_pixels.pop_front();
          if (m_axis_tdata_o !== bco_pkg::OUT_DATA_W'(want.fg) ||
              m_axis_tlast_o !== want.last)
            flag_mismatch($sformatf(
                "result %0d: expected fg %b last %b, got data 0x%02h last %b",
                results_seen, want.fg, want.last, m_axis_tdata_o, m_axis_tlast_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long without any handshake on either side
  // ---------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
sv/bco_pkg.sv
sv/bco_ram.sv
sv/bco_fifo.sv
sv/bco_front.sv
sv/bco_window.sv
sv/bco_back.sv
sv/binary_cross_morphology_open_top.sv
sv/bco_sva_chk.sv
sim/binary_cross_morphology_open_top_tb.sv
